@@ src/quadratic_probe_hash_table_defines.svh @@
// ----------------------------------------------------------------------------
// Quadratic probe hash table assertion macros
// Shared assertion wrappers clocked on clk_i; QPHT_ASSERT is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_PROBE_HASH_TABLE_DEFINES_SVH
`define QUADRATIC_PROBE_HASH_TABLE_DEFINES_SVH

// Checked only while out of reset.
`define QPHT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define QPHT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/qpht_pkg.sv @@
// ----------------------------------------------------------------------------
// Quadratic probe hash table package
// Shared constants, status codes and the stored entry layout.
// ----------------------------------------------------------------------------
package qpht_pkg;

  localparam int TableSizeDef = 1024;

  localparam int CourseW  = 16;
  localparam int YearW    = 12;
  localparam int ProfW    = 32;
  localparam int HandleW  = 16;
  localparam int StatusW  = 2;
  localparam int SlotOutW = 10;
  localparam int CountW   = 11;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef enum logic [StatusW-1:0] {
    STAT_STORED = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_FOUND  = 2'd2,
    STAT_MISS   = 2'd3
  } status_e;

  typedef struct packed {
    logic               valid;
    logic [CourseW-1:0] course;
    logic [YearW-1:0]   year;
    logic [ProfW-1:0]   prof;
    logic [HandleW-1:0] handle;
  } entry_t;

endpackage

@@ src/quadratic_probe_hash_table.sv @@
// ----------------------------------------------------------------------------
// Quadratic probe hash table
// Open-addressing table with cumulative quadratic probing for insert and search.
// ----------------------------------------------------------------------------
// Flow: when TABLE_SIZE is not a power of two, the course number is first reduced
// by subtracting shifted multiples of TABLE_SIZE; each probe step then reads one
// slot from the memory, whose read data is registered, and checks it.
// A new word is accepted only after the previous result has been loaded into the
// output register, which waits while the output is stalled. Reset: a clearing
// pass empties every slot; in_ready_o is low until it finishes.
`include "quadratic_probe_hash_table_defines.svh"

module quadratic_probe_hash_table #(
  parameter int TableSize = qpht_pkg::TableSizeDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         func_i,
  input  logic [qpht_pkg::CourseW-1:0] course_number_i,
  input  logic [qpht_pkg::YearW-1:0]   course_year_i,
  input  logic [qpht_pkg::ProfW-1:0]   prof_id_i,
  input  logic [qpht_pkg::HandleW-1:0] entry_handle_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [qpht_pkg::StatusW-1:0] status_o,
  output logic [qpht_pkg::SlotOutW-1:0] slot_index_o,
  output logic [qpht_pkg::HandleW-1:0] found_handle_o,
  output logic [qpht_pkg::CountW-1:0]  probe_count_o,
  output logic                         collided_o
);

  function automatic int kmax_f(int t);
    int k;
    k = 0;
    for (int i = 1; i < 17; i++) begin
      if ((t << i) <= 65535) begin
        k = i;
      end
    end
    return k;
  endfunction

  localparam int IdxW   = $clog2(TableSize);
  localparam int SumW   = IdxW + 1;
  localparam int CntW   = $clog2(TableSize + 1);
  localparam int KMax   = kmax_f(TableSize);
  localparam bit IsPow2 = (TableSize & (TableSize - 1)) == 0;
  localparam int EntryW = $bits(qpht_pkg::entry_t);
  localparam int CW     = qpht_pkg::CourseW;

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_RED  = 2'd2;
  localparam logic [1:0] S_CHK  = 2'd3;

  localparam logic [SumW-1:0] TSum = SumW'(TableSize);

  function automatic logic [IdxW-1:0] wrap_f(logic [SumW-1:0] x);
    logic [SumW-1:0] r;
    r = (x >= TSum) ? (x - TSum) : x;
    return r[IdxW-1:0];
  endfunction

  logic [1:0]          state_q, state_d;
  logic [IdxW-1:0]     clr_q, clr_d;
  logic [IdxW-1:0]     slot_q, slot_d;
  logic [IdxW-1:0]     nsq_q, nsq_d;
  logic [IdxW-1:0]     odd_q, odd_d;
  logic [CntW-1:0]     steps_q, steps_d;
  logic [CW-1:0]       rem_q, rem_d;
  logic [4:0]          k_q, k_d;

  logic                op_q;
  logic [CW-1:0]       course_q;
  logic [qpht_pkg::YearW-1:0]   year_q;
  logic [qpht_pkg::ProfW-1:0]   prof_q;
  logic [qpht_pkg::HandleW-1:0] handle_q;

  logic                out_valid_q;
  qpht_pkg::status_e   status_q, res_status;
  logic [IdxW-1:0]     oslot_q, res_slot;
  logic [qpht_pkg::HandleW-1:0] ohandle_q, res_handle;
  logic [CntW-1:0]     ocount_q;
  logic                ocol_q, res_col;
  logic                out_load;

  logic                take;
  logic                out_free;
  logic                rd_en;
  logic [IdxW-1:0]     rd_addr;
  logic                we;
  logic [IdxW-1:0]     waddr;
  qpht_pkg::entry_t    wdata;
  qpht_pkg::entry_t    rdata;
  logic [EntryW-1:0]   rdata_raw;

  logic [IdxW+CW-1:0]  home_ext;
  logic [IdxW+CW-1:0]  rem_ext;
  logic [31:0]         red_sub;
  logic [31:0]         red_lhs;
  logic [CW-1:0]       rem_next;
  logic [IdxW-1:0]     slot_adv;
  logic                key_match;
  logic                at_limit;
  logic [IdxW+qpht_pkg::SlotOutW-1:0] slot_out_ext;
  logic [CntW+qpht_pkg::CountW-1:0]   cnt_out_ext;

  assign take       = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign rdata      = qpht_pkg::entry_t'(rdata_raw);

  assign home_ext = {{IdxW{1'b0}}, course_number_i};
  assign red_sub  = 32'(TableSize) << k_q;
  assign red_lhs  = {16'b0, rem_q};
  assign rem_next = (red_lhs >= red_sub) ? 16'(red_lhs - red_sub) : rem_q;
  assign rem_ext  = {{IdxW{1'b0}}, rem_next};
  assign slot_adv = wrap_f({1'b0, slot_q} + {1'b0, nsq_q});
  assign at_limit = (steps_q == CntW'(TableSize));
  assign key_match = (rdata.course == course_q) && (rdata.year == year_q) &&
                     (rdata.prof == prof_q);

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    slot_d     = slot_q;
    nsq_d      = nsq_q;
    odd_d      = odd_q;
    steps_d    = steps_q;
    rem_d      = rem_q;
    k_d        = k_q;
    rd_en      = 1'b0;
    rd_addr    = slot_q;
    we         = 1'b0;
    waddr      = slot_q;
    wdata      = '{valid: 1'b1, course: course_q, year: year_q, prof: prof_q,
                   handle: handle_q};
    out_load   = 1'b0;
    res_status = qpht_pkg::STAT_MISS;
    res_slot   = '0;
    res_handle = '0;
    res_col    = 1'b0;
    case (state_q)
      S_CLR: begin
        we      = 1'b1;
        waddr   = clr_q;
        wdata   = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == IdxW'(TableSize - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (take) begin
          steps_d = '0;
          nsq_d   = IdxW'(1);
          odd_d   = IdxW'(3);
          if (IsPow2) begin
            slot_d  = home_ext[IdxW-1:0];
            rd_en   = 1'b1;
            rd_addr = home_ext[IdxW-1:0];
            state_d = S_CHK;
          end else begin
            rem_d   = course_number_i;
            k_d     = 5'(KMax);
            state_d = S_RED;
          end
        end
      end
      S_RED: begin
        rem_d = rem_next;
        k_d   = k_q - 1'b1;
        if (k_q == '0) begin
          slot_d  = rem_ext[IdxW-1:0];
          rd_en   = 1'b1;
          rd_addr = rem_ext[IdxW-1:0];
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (op_q == qpht_pkg::FUNC_INSERT) begin
          if (!rdata.valid || at_limit) begin
            if (out_free) begin
              out_load = 1'b1;
              state_d  = S_IDLE;
              if (!rdata.valid) begin
                we         = 1'b1;
                res_status = qpht_pkg::STAT_STORED;
                res_slot   = slot_q;
                res_col    = (steps_q != '0);
              end else begin
                res_status = qpht_pkg::STAT_FULL;
                res_col    = 1'b1;
              end
            end
          end else begin
            slot_d  = slot_adv;
            nsq_d   = wrap_f({1'b0, nsq_q} + {1'b0, odd_q});
            odd_d   = wrap_f({1'b0, odd_q} + SumW'(2));
            steps_d = steps_q + 1'b1;
            rd_en   = 1'b1;
            rd_addr = slot_adv;
          end
        end else begin
          if (!rdata.valid || key_match || at_limit) begin
            if (out_free) begin
              out_load = 1'b1;
              state_d  = S_IDLE;
              if (rdata.valid && key_match) begin
                res_status = qpht_pkg::STAT_FOUND;
                res_slot   = slot_q;
                res_handle = rdata.handle;
              end
            end
          end else begin
            slot_d  = slot_adv;
            nsq_d   = wrap_f({1'b0, nsq_q} + {1'b0, odd_q});
            odd_d   = wrap_f({1'b0, odd_q} + SumW'(2));
            steps_d = steps_q + 1'b1;
            rd_en   = 1'b1;
            rd_addr = slot_adv;
          end
        end
      end
      default: begin
        state_d = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      slot_q      <= '0;
      nsq_q       <= '0;
      odd_q       <= '0;
      steps_q     <= '0;
      rem_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      slot_q  <= slot_d;
      nsq_q   <= nsq_d;
      odd_q   <= odd_d;
      steps_q <= steps_d;
      rem_q   <= rem_d;
      k_q     <= k_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q     <= func_i;
      course_q <= course_number_i;
      year_q   <= course_year_i;
      prof_q   <= prof_id_i;
      handle_q <= entry_handle_i;
    end
    if (out_load) begin
      status_q  <= res_status;
      oslot_q   <= res_slot;
      ohandle_q <= res_handle;
      ocount_q  <= steps_q;
      ocol_q    <= res_col;
    end
  end

  qpht_mem #(
    .Depth (TableSize),
    .Width (EntryW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata_raw)
  );

  assign slot_out_ext = {{qpht_pkg::SlotOutW{1'b0}}, oslot_q};
  assign cnt_out_ext  = {{qpht_pkg::CountW{1'b0}}, ocount_q};

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign slot_index_o   = slot_out_ext[qpht_pkg::SlotOutW-1:0];
  assign found_handle_o = ohandle_q;
  assign probe_count_o  = cnt_out_ext[qpht_pkg::CountW-1:0];
  assign collided_o     = ocol_q;

  `QPHT_ASSERT_ALWAYS(a_clr_blocks_input, (state_q == S_CLR) |-> !in_ready_o, "input taken during clearing pass")
  `QPHT_ASSERT(a_no_overwrite, (we && state_q == S_CHK) |-> !rdata.valid, "insert overwrote an occupied slot")
  `QPHT_ASSERT(a_steps_bound, steps_q <= CntW'(TableSize), "probe step count exceeded table size")
  `QPHT_ASSERT(a_slot_bound, {1'b0, slot_q} < TSum, "probe slot outside the table")
  `QPHT_ASSERT(a_result_from_check, $rose(out_valid_q) |-> $past(state_q == S_CHK), "result raised outside the check state")

endmodule

@@ src/qpht_mem.sv @@
// ----------------------------------------------------------------------------
// Quadratic probe hash table slot memory
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module qpht_mem #(
  parameter  int Depth = 1024,
  parameter  int Width = 8,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
